>>> hdl/pce_pkg.sv
`timescale 1ns / 1ps

package pce_pkg;

  localparam int MIN_N = 2;
  localparam int MIN_K = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_CODE_OUTPUTS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONSTRAINT_LEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_MODE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECURSIVE_MODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_POLY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GENERATOR_SET  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PUNCT_COUNT    = 3'd6;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_DATA  = 2'd1;
  localparam logic [1:0] FUNC_LOAD  = 2'd2;
  localparam logic [1:0] FUNC_END   = 2'd3;

  localparam logic [1:0] TERM_FLUSH    = 2'd0;
  localparam logic [1:0] TERM_TAILBITE = 2'd1;

  localparam logic [1:0] STATUS_OK            = 2'd0;
  localparam logic [1:0] STATUS_REC_TAILBITE  = 2'd1;
  localparam logic [1:0] STATUS_NO_SYSTEMATIC = 2'd2;

  typedef enum logic [2:0] {
    OP_START,
    OP_DATA,
    OP_LOAD,
    OP_FLUSH,
    OP_ERROR
  } pce_op_e;

  // One classified word waiting between the front and the back.
  typedef struct packed {
    pce_op_e     op;
    logic        data_bit;
    logic [15:0] value;
    logic [9:0]  index;
    logic [1:0]  status;
  } pce_item_t;

  // Effective configuration, already saturated, with the derived status.
  typedef struct packed {
    logic [2:0]  n;
    logic [4:0]  k;
    logic [1:0]  term;
    logic        rec;
    logic [15:0] fb;
    logic [63:0] gen;
    logic [10:0] punct_count;
    logic [1:0]  status;
  } pce_cfg_t;

  function automatic logic is_one_hot(input logic [15:0] v);
    return (v != 16'd0) && ((v & (v - 16'd1)) == 16'd0);
  endfunction

endpackage

>>> hdl/pce_if.sv
`timescale 1ns / 1ps

interface pce_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic        data_bit;
  logic [14:0] seed_bits;
  logic [9:0]  punct_index;
  logic [15:0] punct_position;

  modport source (
    output valid, func, data_bit, seed_bits, punct_index, punct_position,
    input  ready
  );
  modport sink (
    input  valid, func, data_bit, seed_bits, punct_index, punct_position,
    output ready
  );
endinterface

interface pce_out_if;
  logic       valid;
  logic       ready;
  logic       code_bit;
  logic       last;
  logic [1:0] status;

  modport source (
    output valid, code_bit, last, status,
    input  ready
  );
  modport sink (
    input  valid, code_bit, last, status,
    output ready
  );
endinterface

>>> hdl/pce_ram.sv
`timescale 1ns / 1ps

module pce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old contents when the same address is written.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/pce_fifo.sv
`timescale 1ns / 1ps

module pce_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pce_pkg::pce_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output pce_pkg::pce_item_t head_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  pce_pkg::pce_item_t entry_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = entry_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= item_i;
    end
  end

endmodule

>>> hdl/pce_front.sv
`timescale 1ns / 1ps

module pce_front #(
  parameter int PUNCT_DEPTH = 1024
) (
  input  pce_pkg::pce_cfg_t  cfg_i,
  pce_in_if.sink             in_i,
  input  logic               fifo_full_i,
  output logic               push_o,
  output pce_pkg::pce_item_t item_o
);

  logic        keep;
  logic [14:0] seed_mask;

  assign seed_mask = 15'((16'd1 << (cfg_i.k - 5'd1)) - 16'd1);

  always_comb begin
    keep            = 1'b1;
    item_o.op       = pce_pkg::OP_START;
    item_o.data_bit = in_i.data_bit;
    item_o.value    = '0;
    item_o.index    = in_i.punct_index;
    item_o.status   = cfg_i.status;
    case (in_i.func)
      pce_pkg::FUNC_START: begin
        item_o.op = pce_pkg::OP_START;
        if (cfg_i.term == pce_pkg::TERM_TAILBITE) begin
          item_o.value = 16'(in_i.seed_bits & seed_mask);
        end
      end
      pce_pkg::FUNC_DATA: begin
        item_o.op = (cfg_i.status != pce_pkg::STATUS_OK) ? pce_pkg::OP_ERROR
                                                         : pce_pkg::OP_DATA;
      end
      pce_pkg::FUNC_LOAD: begin
        item_o.op    = pce_pkg::OP_LOAD;
        item_o.value = in_i.punct_position;
        // Slots beyond the table are dropped here and never reach the back.
        keep         = (32'(in_i.punct_index) < PUNCT_DEPTH);
      end
      pce_pkg::FUNC_END: begin
        item_o.op = (cfg_i.status != pce_pkg::STATUS_OK) ? pce_pkg::OP_ERROR
                                                         : pce_pkg::OP_FLUSH;
        keep      = (cfg_i.term == pce_pkg::TERM_FLUSH);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_i.ready = !fifo_full_i;
  assign push_o     = in_i.valid && !fifo_full_i && keep;

endmodule

>>> hdl/pce_back.sv
`timescale 1ns / 1ps

module pce_back #(
  parameter int MAX_K       = 16,
  parameter int MAX_N       = 4,
  parameter int PUNCT_DEPTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pce_pkg::pce_cfg_t              cfg_i,
  input  logic                           head_valid_i,
  input  pce_pkg::pce_item_t             head_i,
  output logic                           pop_o,
  output logic                           ram_we_o,
  output logic [$clog2(PUNCT_DEPTH)-1:0] ram_waddr_o,
  output logic [15:0]                    ram_wdata_o,
  output logic [$clog2(PUNCT_DEPTH)-1:0] ram_raddr_o,
  input  logic [15:0]                    ram_rdata_i,
  pce_out_if.source                      out_o
);

  localparam int AW    = $clog2(PUNCT_DEPTH);
  localparam int PTR_W = $clog2(PUNCT_DEPTH + 1);
  localparam int UW    = (PTR_W > 11) ? PTR_W : 11;
  localparam int JW    = $clog2(MAX_N);
  localparam int TW    = $clog2(MAX_K - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DATA   = 4'b0010,
    S_TAIL   = 4'b0100,
    S_SETTLE = 4'b1000
  } pce_state_e;

  pce_state_e       state_q, state_d;
  logic [MAX_K-1:0] sr_q, sr_d;
  logic [JW-1:0]    j_q, j_d;
  logic [TW-1:0]    t_q, t_d;
  logic             dbit_q, dbit_d;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [15:0]      cnt_q, cnt_d;

  // One surviving bit is held back until it is known whether it ends its word.
  logic       pend_valid_q, pend_valid_d;
  logic       pend_done_q, pend_done_d;
  logic       pend_bit_q, pend_bit_d;
  logic [1:0] pend_status_q, pend_status_d;

  logic       out_valid_q, out_valid_d;
  logic       out_bit_q, out_bit_d;
  logic       out_last_q, out_last_d;
  logic [1:0] out_status_q, out_status_d;

  logic             head_gen;
  logic             gen_active, tail, gen_dbit, is_last, is_err, j_last;
  logic [JW-1:0]    j_sel;
  logic [MAX_K-1:0] cur_reg, ins_reg;
  logic             fb_par, ins_bit, sys, code, del;
  logic [15:0]      gen_word;
  logic [1:0]       gen_status;
  logic [UW-1:0]    used;
  logic             out_free, pend_cur, fin_push, adv;

  assign head_gen = head_valid_i && (head_i.op == pce_pkg::OP_DATA ||
                                     head_i.op == pce_pkg::OP_FLUSH ||
                                     head_i.op == pce_pkg::OP_ERROR);
  assign j_last   = (j_q == JW'(cfg_i.n - 3'd1));

  assign fb_par  = ^(sr_q & cfg_i.fb[MAX_K-1:0]);
  assign ins_bit = head_i.data_bit ^ (cfg_i.rec & fb_par);
  assign ins_reg = sr_q | (MAX_K'(ins_bit) << (cfg_i.k - 5'd1));

  always_comb begin
    gen_active = 1'b0;
    tail       = 1'b0;
    gen_dbit   = dbit_q;
    is_last    = 1'b0;
    is_err     = 1'b0;
    j_sel      = j_q;
    cur_reg    = sr_q;
    case (state_q)
      S_IDLE: begin
        gen_active = head_gen;
        j_sel      = '0;
        tail       = (head_i.op == pce_pkg::OP_FLUSH);
        gen_dbit   = head_i.data_bit;
        is_err     = (head_i.op == pce_pkg::OP_ERROR);
        is_last    = is_err;
        cur_reg    = (head_i.op == pce_pkg::OP_DATA) ? ins_reg : sr_q;
      end
      S_DATA: begin
        gen_active = 1'b1;
        is_last    = j_last;
      end
      S_TAIL: begin
        gen_active = 1'b1;
        tail       = 1'b1;
        is_last    = j_last && (t_q == TW'(cfg_i.k - 5'd2));
      end
      default: begin
        gen_active = 1'b0;
      end
    endcase
  end

  assign gen_word   = cfg_i.gen[{2'(j_sel), 4'b0000} +: 16];
  assign sys        = cfg_i.rec && pce_pkg::is_one_hot(gen_word);
  assign code       = is_err ? 1'b0 :
                      sys    ? (tail ? fb_par : gen_dbit) :
                               ^(cur_reg & gen_word[MAX_K-1:0]);
  assign gen_status = is_err ? head_i.status : pce_pkg::STATUS_OK;

  assign used = (UW'(cfg_i.punct_count) > UW'(PUNCT_DEPTH)) ? UW'(PUNCT_DEPTH)
                                                            : UW'(cfg_i.punct_count);
  assign del  = !is_err && (UW'(ptr_q) < used) && (cnt_q == ram_rdata_i);

  assign out_free = !out_valid_q || out_o.ready;
  assign pend_cur = pend_valid_q && !pend_done_q;
  assign fin_push = pend_valid_q && pend_done_q && out_free;
  assign adv      = gen_active &&
                    (del || (pend_cur ? out_free : (!pend_valid_q || fin_push)));

  always_comb begin
    state_d       = state_q;
    sr_d          = sr_q;
    j_d           = j_q;
    t_d           = t_q;
    dbit_d        = dbit_q;
    ptr_d         = ptr_q;
    cnt_d         = cnt_q;
    pend_valid_d  = pend_valid_q;
    pend_done_d   = pend_done_q;
    pend_bit_d    = pend_bit_q;
    pend_status_d = pend_status_q;
    out_valid_d   = out_valid_q;
    out_bit_d     = out_bit_q;
    out_last_d    = out_last_q;
    out_status_d  = out_status_q;
    pop_o         = 1'b0;
    ram_we_o      = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (fin_push) begin
      out_valid_d  = 1'b1;
      out_bit_d    = pend_bit_q;
      out_last_d   = 1'b1;
      out_status_d = pend_status_q;
      pend_valid_d = 1'b0;
      pend_done_d  = 1'b0;
    end

    if (adv) begin
      if (!del) begin
        if (pend_cur) begin
          out_valid_d  = 1'b1;
          out_bit_d    = pend_bit_q;
          out_last_d   = 1'b0;
          out_status_d = pend_status_q;
        end
        pend_valid_d  = 1'b1;
        pend_done_d   = is_last;
        pend_bit_d    = code;
        pend_status_d = gen_status;
      end else if (is_last && pend_cur) begin
        pend_done_d = 1'b1;
      end
      if (!is_err) begin
        if (del) begin
          ptr_d = ptr_q + PTR_W'(1);
        end
        if (cnt_q != 16'hFFFF) begin
          cnt_d = cnt_q + 16'd1;
        end
      end
    end

    case (state_q)
      S_IDLE: begin
        if (head_valid_i) begin
          case (head_i.op)
            pce_pkg::OP_START: begin
              pop_o = 1'b1;
              cnt_d = '0;
              ptr_d = '0;
              sr_d  = head_i.value[MAX_K-1:0];
            end
            pce_pkg::OP_LOAD: begin
              pop_o    = 1'b1;
              ram_we_o = 1'b1;
              state_d  = S_SETTLE;
            end
            pce_pkg::OP_DATA: begin
              if (adv) begin
                pop_o   = 1'b1;
                sr_d    = ins_reg;
                dbit_d  = head_i.data_bit;
                j_d     = JW'(1);
                state_d = S_DATA;
              end
            end
            pce_pkg::OP_FLUSH: begin
              if (adv) begin
                pop_o   = 1'b1;
                j_d     = JW'(1);
                t_d     = '0;
                state_d = S_TAIL;
              end
            end
            pce_pkg::OP_ERROR: begin
              pop_o = adv;
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      S_DATA: begin
        if (adv) begin
          if (j_last) begin
            sr_d    = sr_q >> 1;
            j_d     = '0;
            state_d = S_IDLE;
          end else begin
            j_d = j_q + JW'(1);
          end
        end
      end
      S_TAIL: begin
        if (adv) begin
          if (j_last) begin
            sr_d = sr_q >> 1;
            j_d  = '0;
            if (is_last) begin
              state_d = S_IDLE;
            end else begin
              t_d = t_q + TW'(1);
            end
          end else begin
            j_d = j_q + JW'(1);
          end
        end
      end
      S_SETTLE: begin
        // The table read port catches up with the word just written.
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign ram_waddr_o = AW'(head_i.index);
  assign ram_wdata_o = head_i.value;
  assign ram_raddr_o = ptr_d[AW-1:0];

  assign out_o.valid    = out_valid_q;
  assign out_o.code_bit = out_bit_q;
  assign out_o.last     = out_last_q;
  assign out_o.status   = out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sr_q         <= '0;
      j_q          <= '0;
      t_q          <= '0;
      ptr_q        <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      pend_done_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      sr_q         <= sr_d;
      j_q          <= j_d;
      t_q          <= t_d;
      ptr_q        <= ptr_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      pend_done_q  <= pend_done_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dbit_q        <= dbit_d;
    pend_bit_q    <= pend_bit_d;
    pend_status_q <= pend_status_d;
    out_bit_q     <= out_bit_d;
    out_last_q    <= out_last_d;
    out_status_q  <= out_status_d;
  end

  a_pend_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_done_q |-> pend_valid_q)
    else $error("held bit marked final without being valid");

  a_j_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DATA || state_q == S_TAIL) |-> (32'(j_q) < 32'(cfg_i.n)))
    else $error("coded bit index beyond code outputs");

  a_settle_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SETTLE) |=> (state_q == S_IDLE))
    else $error("table settle cycle did not return to idle");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != pce_pkg::STATUS_OK) |-> out_last_q)
    else $error("error word without last flag");

endmodule

>>> hdl/punctured_convolutional_encoder.sv
`timescale 1ns / 1ps
// Throughput: one coded bit per cycle while the output is not stalled, through the shared
// parity and puncture check with one table read port; a data word codes N bits and a flush
// end word (K-1)*N tail bits. Start and error words are handled in the idle state, and a
// puncture load word also passes through a settle state.
// Reset: asynchronous, clears shift register, counter, pointer, queue and handshakes;
// the puncture table is not cleared and holds nothing usable until it is loaded.

module punctured_convolutional_encoder #(
  parameter int MAX_K       = 16,
  parameter int MAX_N       = 4,
  parameter int PUNCT_DEPTH = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pce_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pce_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  pce_in_if.sink                             in_i,
  pce_out_if.source                          out_o
);

  localparam int AW = $clog2(PUNCT_DEPTH);

  logic [2:0]  code_outputs_q;
  logic [4:0]  constraint_len_q;
  logic [1:0]  term_mode_q;
  logic        recursive_mode_q;
  logic [15:0] feedback_poly_q;
  logic [63:0] generator_set_q;
  logic [10:0] punct_count_q;

  pce_pkg::pce_cfg_t  cfg;
  logic               sys_found;

  logic               push, fifo_full, fifo_empty, pop;
  pce_pkg::pce_item_t push_item, head_item;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [15:0]        ram_wdata, ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_outputs_q   <= 3'(pce_pkg::MIN_N);
      constraint_len_q <= 5'(pce_pkg::MIN_K);
      term_mode_q      <= pce_pkg::TERM_FLUSH;
      recursive_mode_q <= 1'b0;
      feedback_poly_q  <= '0;
      generator_set_q  <= '0;
      punct_count_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pce_pkg::REG_CODE_OUTPUTS:   code_outputs_q   <= cfg_data_i[2:0];
        pce_pkg::REG_CONSTRAINT_LEN: constraint_len_q <= cfg_data_i[4:0];
        pce_pkg::REG_TERM_MODE:      term_mode_q      <= cfg_data_i[1:0];
        pce_pkg::REG_RECURSIVE_MODE: recursive_mode_q <= cfg_data_i[0];
        pce_pkg::REG_FEEDBACK_POLY:  feedback_poly_q  <= cfg_data_i[15:0];
        pce_pkg::REG_GENERATOR_SET:  generator_set_q  <= cfg_data_i;
        pce_pkg::REG_PUNCT_COUNT:    punct_count_q    <= cfg_data_i[10:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.n = (code_outputs_q < 3'(pce_pkg::MIN_N)) ? 3'(pce_pkg::MIN_N) :
            (code_outputs_q > 3'(MAX_N))          ? 3'(MAX_N) : code_outputs_q;
    cfg.k = (constraint_len_q < 5'(pce_pkg::MIN_K)) ? 5'(pce_pkg::MIN_K) :
            (constraint_len_q > 5'(MAX_K))          ? 5'(MAX_K) : constraint_len_q;
    cfg.term        = term_mode_q;
    cfg.rec         = recursive_mode_q;
    cfg.fb          = feedback_poly_q;
    cfg.gen         = generator_set_q;
    cfg.punct_count = punct_count_q;

    sys_found = 1'b0;
    for (int jj = 0; jj < MAX_N; jj++) begin
      if ((3'(jj) < cfg.n) && pce_pkg::is_one_hot(generator_set_q[16*jj +: 16])) begin
        sys_found = 1'b1;
      end
    end

    if (!recursive_mode_q) begin
      cfg.status = pce_pkg::STATUS_OK;
    end else if (term_mode_q == pce_pkg::TERM_TAILBITE) begin
      cfg.status = pce_pkg::STATUS_REC_TAILBITE;
    end else if (sys_found) begin
      cfg.status = pce_pkg::STATUS_OK;
    end else begin
      cfg.status = pce_pkg::STATUS_NO_SYSTEMATIC;
    end
  end

  pce_front #(
    .PUNCT_DEPTH (PUNCT_DEPTH)
  ) u_front (
    .cfg_i       (cfg),
    .in_i        (in_i),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .item_o      (push_item)
  );

  pce_fifo #(
    .DEPTH (4)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .empty_o (fifo_empty),
    .head_o  (head_item)
  );

  pce_ram #(
    .WIDTH (16),
    .DEPTH (PUNCT_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pce_back #(
    .MAX_K       (MAX_K),
    .MAX_N       (MAX_N),
    .PUNCT_DEPTH (PUNCT_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_valid_i (!fifo_empty),
    .head_i       (head_item),
    .pop_o        (pop),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .out_o        (out_o)
  );

endmodule
